>>> design/hts_pkg.sv
// Shared types and constants for the heater tool supervisor.
`default_nettype none
package hts_pkg;

    localparam int unsigned TICKS_PER_SECOND = 10;
    localparam int unsigned TICK_W = $clog2(TICKS_PER_SECOND);

    localparam int unsigned TEMP_W  = 10;
    localparam int unsigned SP_W    = 9;
    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned GAIN_W  = 8;
    localparam int unsigned PRESS_W = 8;
    localparam int unsigned IGN_W   = 2;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned CNT_W   = 8;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned APB_ADDR_W  = 5;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [TEMP_W-1:0]  HOT_TEMP      = 10'd55;
    localparam logic [TEMP_W:0]    NEAR_BAND     = 11'd15;
    localparam logic [PRESS_W-1:0] PRESS_LONG    = 8'd7;
    localparam logic [PRESS_W-1:0] PRESS_SHORT   = 8'd2;
    localparam logic [PRESS_W-1:0] PRESS_MAX     = 8'd255;
    localparam logic [IGN_W-1:0]   IGNORE_TICKS  = 2'd3;
    localparam logic [TICK_W-1:0]  BLINK_TICK    = TICK_W'(4);
    localparam logic [SEC_W:0]     SEC_PER_MIN   = 7'd60;
    localparam logic [DUTY_W-1:0]  DUTY_CAP      = 7'd100;

    localparam logic [GAIN_W-1:0] RST_GAIN     = 8'd4;
    localparam logic [DUTY_W-1:0] RST_MAX_DUTY = 7'd60;
    localparam logic [SP_W-1:0]   RST_DEF_SP   = 9'd320;

    typedef enum logic [2:0] {
        REG_GAIN     = 3'd0,
        REG_MAX_DUTY = 3'd1,
        REG_DEF_SP   = 3'd2,
        REG_IDLE_TO  = 3'd3,
        REG_OFF_TO   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] proportional_gain;
        logic [DUTY_W-1:0] max_duty;
        logic [SP_W-1:0]   default_setpoint;
        logic [CNT_W-1:0]  idle_timeout_seconds;
        logic [CNT_W-1:0]  off_timeout_minutes;
    } t_cfg;

    typedef struct packed {
        logic              motion_event;
        logic              button_level;
        logic              button_event;
        logic [TEMP_W-1:0] tip_temperature;
    } t_item;

    typedef struct packed {
        logic              status_led;
        logic              hot_led;
        logic              in_standby;
        logic [SP_W-1:0]   current_setpoint;
        logic [DUTY_W-1:0] heater_duty;
    } t_result;

endpackage
`default_nettype wire

>>> design/hts_apb_regs.sv
// APB configuration register file for the heater tool supervisor.
`default_nettype none
module hts_apb_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [hts_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire  [hts_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hts_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output hts_pkg::t_cfg                    o_cfg
);
    import hts_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_GAIN:     n_cfg.proportional_gain    = pwdata[GAIN_W-1:0];
                REG_MAX_DUTY: n_cfg.max_duty             = pwdata[DUTY_W-1:0];
                REG_DEF_SP:   n_cfg.default_setpoint     = pwdata[SP_W-1:0];
                REG_IDLE_TO:  n_cfg.idle_timeout_seconds = pwdata[CNT_W-1:0];
                REG_OFF_TO:   n_cfg.off_timeout_minutes  = pwdata[CNT_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GAIN:     prdata = APB_DATA_W'(r_cfg.proportional_gain);
            REG_MAX_DUTY: prdata = APB_DATA_W'(r_cfg.max_duty);
            REG_DEF_SP:   prdata = APB_DATA_W'(r_cfg.default_setpoint);
            REG_IDLE_TO:  prdata = APB_DATA_W'(r_cfg.idle_timeout_seconds);
            REG_OFF_TO:   prdata = APB_DATA_W'(r_cfg.off_timeout_minutes);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.proportional_gain    <= RST_GAIN;
            r_cfg.max_duty             <= RST_MAX_DUTY;
            r_cfg.default_setpoint     <= RST_DEF_SP;
            r_cfg.idle_timeout_seconds <= '0;
            r_cfg.off_timeout_minutes  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

>>> design/hts_tick_core.sv
// Per-tick supervisor state and next-state/result logic.
`default_nettype none
module hts_tick_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_step,
    input  wire hts_pkg::t_item    i_item,
    input  wire hts_pkg::t_cfg     i_cfg,
    output hts_pkg::t_result       o_res
);
    import hts_pkg::*;

    logic [SP_W-1:0]    r_sp,    n_sp;
    logic [SP_W-1:0]    r_sv,    n_sv;
    logic               r_stby,  n_stby;
    logic               r_pend,  n_pend;
    logic [PRESS_W-1:0] r_pt,    n_pt;
    logic [IGN_W-1:0]   r_ign,   n_ign;
    logic [TICK_W-1:0]  r_tis,   n_tis;
    logic [CNT_W-1:0]   r_idle,  n_idle;
    logic [SEC_W-1:0]   r_secs,  n_secs;
    logic [CNT_W-1:0]   r_mins,  n_mins;

    logic [DUTY_W-1:0]         w_duty;
    logic                      w_led;
    logic [DUTY_W-1:0]         w_limit;
    logic [TEMP_W-1:0]         w_err;
    logic [GAIN_W+TEMP_W-1:0]  w_prod;
    logic [TICK_W:0]           w_tis_inc;
    logic [SEC_W:0]            w_secs_inc;
    logic [CNT_W-1:0]          w_idle_inc;
    logic [CNT_W-1:0]          w_mins_inc;

    always_comb begin
        n_sp = r_sp; n_sv = r_sv; n_stby = r_stby; n_pend = r_pend; n_pt = r_pt;
        n_ign = r_ign; n_tis = r_tis; n_idle = r_idle; n_secs = r_secs; n_mins = r_mins;
        w_led = 1'b0;
        w_duty = '0;
        w_err = '0;
        w_prod = '0;
        w_idle_inc = '0;
        w_secs_inc = '0;
        w_mins_inc = '0;

        // button
        n_pend = r_pend | i_item.button_event;
        if (r_ign != '0) begin
            n_ign  = r_ign - IGN_W'(1);
            n_pend = 1'b0;
        end else if (n_pend) begin
            if (n_pt != PRESS_MAX) n_pt = n_pt + PRESS_W'(1);
            if (!i_item.button_level || n_pt >= PRESS_LONG) begin
                if (n_sp != '0 && n_pt >= PRESS_SHORT) begin
                    n_sv   = n_sp;
                    n_sp   = '0;
                    n_stby = 1'b0;
                    n_ign  = IGNORE_TICKS;
                end else if (n_sp == '0 && n_pt >= PRESS_LONG) begin
                    n_sp   = (n_sv != '0) ? n_sv : i_cfg.default_setpoint;
                    n_stby = 1'b0;
                    n_idle = '0;
                    n_secs = '0;
                    n_mins = '0;
                    n_ign  = IGNORE_TICKS;
                end
                n_pend = 1'b0;
                n_pt   = '0;
            end
        end

        // status LED
        if (n_sp != '0) begin
            if ({1'b0, i_item.tip_temperature} + NEAR_BAND < {2'b00, n_sp})
                w_led = (r_tis > BLINK_TICK);
            else
                w_led = 1'b1;
        end

        // duty
        w_limit = (i_cfg.max_duty > DUTY_CAP) ? DUTY_CAP : i_cfg.max_duty;
        if (n_sp != '0 && i_item.tip_temperature <= {1'b0, n_sp}) begin
            w_err  = {1'b0, n_sp} - i_item.tip_temperature;
            w_prod = (GAIN_W+TEMP_W)'(i_cfg.proportional_gain) * (GAIN_W+TEMP_W)'(w_err);
            if (w_prod > (GAIN_W+TEMP_W)'(w_limit))
                w_duty = w_limit;
            else
                w_duty = w_prod[DUTY_W-1:0];
        end

        // second tick and timeouts
        w_tis_inc = {1'b0, r_tis} + (TICK_W+1)'(1);
        if (w_tis_inc >= (TICK_W+1)'(TICKS_PER_SECOND)) begin
            n_tis = '0;
            if (n_sp != '0) begin
                if (i_cfg.idle_timeout_seconds != '0 &&
                    n_idle < i_cfg.idle_timeout_seconds) begin
                    w_idle_inc = n_idle + CNT_W'(1);
                    n_idle = w_idle_inc;
                    if (w_idle_inc == i_cfg.idle_timeout_seconds) begin
                        n_sv   = n_sp;
                        n_sp   = '0;
                        n_stby = 1'b1;
                    end
                end else if (i_cfg.idle_timeout_seconds == '0) begin
                    n_idle = '0;
                end
                if (i_cfg.off_timeout_minutes != '0 &&
                    n_mins < i_cfg.off_timeout_minutes) begin
                    w_secs_inc = {1'b0, n_secs} + (SEC_W+1)'(1);
                    if (w_secs_inc >= SEC_PER_MIN) begin
                        n_secs = '0;
                        w_mins_inc = n_mins + CNT_W'(1);
                        n_mins = w_mins_inc;
                        if (w_mins_inc == i_cfg.off_timeout_minutes) begin
                            n_sv   = n_sp;
                            n_sp   = '0;
                            n_stby = 1'b0;
                        end
                    end else begin
                        n_secs = w_secs_inc[SEC_W-1:0];
                    end
                end else if (i_cfg.off_timeout_minutes == '0) begin
                    n_secs = '0;
                    n_mins = '0;
                end
            end
        end else begin
            n_tis = w_tis_inc[TICK_W-1:0];
        end

        // motion
        if (i_item.motion_event) begin
            if (n_stby && n_sp == '0 && n_sv != '0) begin
                n_sp   = n_sv;
                n_stby = 1'b0;
            end else if (n_sp == '0) begin
                w_led = 1'b1;
            end
            n_idle = '0;
            n_secs = '0;
            n_mins = '0;
        end
    end

    assign o_res.heater_duty      = w_duty;
    assign o_res.current_setpoint = n_sp;
    assign o_res.in_standby       = n_stby;
    assign o_res.hot_led          = (i_item.tip_temperature > HOT_TEMP);
    assign o_res.status_led       = w_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0; r_sv <= '0; r_stby <= 1'b0; r_pend <= 1'b0; r_pt <= '0;
            r_ign <= '0; r_tis <= '0; r_idle <= '0; r_secs <= '0; r_mins <= '0;
        end else if (i_step) begin
            r_sp <= n_sp; r_sv <= n_sv; r_stby <= n_stby; r_pend <= n_pend; r_pt <= n_pt;
            r_ign <= n_ign; r_tis <= n_tis; r_idle <= n_idle; r_secs <= n_secs;
            r_mins <= n_mins;
        end
    end

    a_ignore_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ign != '0) |-> !r_pend)
        else $error("press pending during ignore window");

    a_press_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pt <= PRESS_LONG)
        else $error("press counter ran past long press");

    a_seconds_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_secs < SEC_PER_MIN[SEC_W-1:0])
        else $error("off seconds counter missed wrap");

    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> (w_duty <= w_limit))
        else $error("heater duty above limit");

endmodule
`default_nettype wire

>>> design/heater_tool_supervisor_unit.sv
// Top level: stream input register, tick core, result register, APB registers.
// Throughput: one tick per cycle unless the result side stalls; the input register
// refills while a result waits.
// The state update runs in one pass of the tick core between the two registers.
// Reset (synchronous, active low) clears the valid flags and tick core state and loads register defaults.
`default_nettype none
module heater_tool_supervisor_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] tip_temperature, [10] button_event, [11] button_level,
    // [12] motion_event, [15:13] zero
    input  wire  [hts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [6:0] heater_duty, [15:7] current_setpoint, [16] in_standby,
    // [17] hot_led, [18] status_led, [23:19] zero
    output logic [hts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [hts_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [hts_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hts_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hts_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    logic    w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_res);

    hts_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hts_tick_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                r_in_valid <= 1'b1;
            else if (w_adv)
                r_in_valid <= 1'b0;
            if (w_adv)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            r_in_item <= t_item'(s_axis_tdata[$bits(t_item)-1:0]);
        if (w_adv)
            r_out_res <= w_res;
    end

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_held_result_blocks_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_adv)
        else $error("core stepped while result stalled");

    a_full_input_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted with both registers full");

endmodule
`default_nettype wire

>>> verif/hts_checker.sv
// Checker for the heater tool supervisor: tracks register writes, predicts each tick's result.
`timescale 1ns / 1ps
module hts_checker
    import hts_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    input  wire                    i_s_tready,
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,
    input  wire                    i_m_tvalid,
    input  wire                    i_m_tready,
    input  wire [OUT_TDATA_W-1:0]  i_m_tdata,
    input  wire                    i_psel,
    input  wire                    i_penable,
    input  wire                    i_pwrite,
    input  wire [APB_ADDR_W-1:0]   i_paddr,
    input  wire [APB_DATA_W-1:0]   i_pwdata,
    input  wire                    i_pready,
    output int                     o_pending,
    output logic                   o_heating,
    output int                     o_fail_count
);

    t_cfg               cfg;
    logic [SP_W-1:0]    setpoint;
    logic [SP_W-1:0]    saved_sp;
    logic               standby;
    logic               press_pending;
    logic [PRESS_W-1:0] press_ticks;
    logic [IGN_W-1:0]   ignore_left;
    logic [TICK_W-1:0]  tick_phase;
    logic [CNT_W-1:0]   idle_secs;
    logic [SEC_W-1:0]   off_secs;
    logic [CNT_W-1:0]   off_mins;

    t_result            expected_results[$];
    t_result            want;
    t_result            got;
    t_result            next_result;
    int                 fails;

    initial begin
        fails = 0;
    end

    task automatic check_field(input string field, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            if (fails < 10)
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $realtime, field, exp_v, act_v);
            fails++;
        end
    endtask

    task automatic clear_timers();
        idle_secs = '0;
        off_secs  = '0;
        off_mins  = '0;
    endtask

    task automatic predict_tick(input t_item it, output t_result r);
        int  temp_i;
        int  sp_i;
        int  limit;
        int  p;
        int  duty;
        logic led;
        temp_i = int'(it.tip_temperature);
        led    = 1'b0;
        r      = '0;
        r.hot_led = (temp_i > int'(HOT_TEMP));

        // button
        if (it.button_event)
            press_pending = 1'b1;
        if (ignore_left != '0) begin
            ignore_left   = ignore_left - 1'b1;
            press_pending = 1'b0;
        end else if (press_pending) begin
            if (press_ticks != PRESS_MAX)
                press_ticks = press_ticks + 1'b1;
            if (!it.button_level || press_ticks >= PRESS_LONG) begin
                if (setpoint != '0 && press_ticks >= PRESS_SHORT) begin
                    saved_sp    = setpoint;
                    setpoint    = '0;
                    standby     = 1'b0;
                    ignore_left = IGNORE_TICKS;
                end else if (setpoint == '0 && press_ticks >= PRESS_LONG) begin
                    setpoint    = (saved_sp != '0) ? saved_sp : cfg.default_setpoint;
                    standby     = 1'b0;
                    clear_timers();
                    ignore_left = IGNORE_TICKS;
                end
                press_pending = 1'b0;
                press_ticks   = '0;
            end
        end

        // status led and duty
        sp_i = int'(setpoint);
        if (setpoint != '0) begin
            if (temp_i + int'(NEAR_BAND) < sp_i)
                led = (tick_phase > BLINK_TICK);
            else
                led = 1'b1;
        end
        limit = (cfg.max_duty > DUTY_CAP) ? int'(DUTY_CAP) : int'(cfg.max_duty);
        if (setpoint == '0 || temp_i > sp_i) begin
            duty = 0;
        end else begin
            p    = int'(cfg.proportional_gain) * (sp_i - temp_i);
            duty = (p > limit) ? limit : p;
        end

        // second boundary and timeouts
        tick_phase = tick_phase + 1'b1;
        if (tick_phase >= TICKS_PER_SECOND) begin
            tick_phase = '0;
            if (setpoint != '0) begin
                if (cfg.idle_timeout_seconds != '0 && idle_secs < cfg.idle_timeout_seconds) begin
                    idle_secs = idle_secs + 1'b1;
                    if (idle_secs == cfg.idle_timeout_seconds) begin
                        saved_sp = setpoint;
                        setpoint = '0;
                        standby  = 1'b1;
                    end
                end else if (cfg.idle_timeout_seconds == '0) begin
                    idle_secs = '0;
                end
                if (cfg.off_timeout_minutes != '0 && off_mins < cfg.off_timeout_minutes) begin
                    off_secs = off_secs + 1'b1;
                    if (off_secs >= SEC_PER_MIN) begin
                        off_secs = '0;
                        off_mins = off_mins + 1'b1;
                        if (off_mins == cfg.off_timeout_minutes) begin
                            saved_sp = setpoint;
                            setpoint = '0;
                            standby  = 1'b0;
                        end
                    end
                end else if (cfg.off_timeout_minutes == '0) begin
                    off_secs = '0;
                    off_mins = '0;
                end
            end
        end

        // motion
        if (it.motion_event) begin
            if (standby && setpoint == '0 && saved_sp != '0) begin
                setpoint = saved_sp;
                standby  = 1'b0;
            end else if (setpoint == '0) begin
                led = 1'b1;
            end
            clear_timers();
        end

        r.heater_duty      = DUTY_W'(duty);
        r.current_setpoint = setpoint;
        r.in_standby       = standby;
        r.status_led       = led;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.proportional_gain    = RST_GAIN;
            cfg.max_duty             = RST_MAX_DUTY;
            cfg.default_setpoint     = RST_DEF_SP;
            cfg.idle_timeout_seconds = '0;
            cfg.off_timeout_minutes  = '0;
            setpoint      = '0;
            saved_sp      = '0;
            standby       = 1'b0;
            press_pending = 1'b0;
            press_ticks   = '0;
            ignore_left   = '0;
            tick_phase    = '0;
            clear_timers();
            expected_results.delete();
            o_pending <= 0;
            o_heating <= 1'b0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[$bits(t_result)-1:0]);
                if (expected_results.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result transaction with no tick outstanding: %h",
                                 $realtime, i_m_tdata);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("heater_duty", want.heater_duty, got.heater_duty);
                    check_field("current_setpoint", want.current_setpoint,
                                got.current_setpoint);
                    check_field("in_standby", want.in_standby, got.in_standby);
                    check_field("hot_led", want.hot_led, got.hot_led);
                    check_field("status_led", want.status_led, got.status_led);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_GAIN:     cfg.proportional_gain    = i_pwdata[GAIN_W-1:0];
                    REG_MAX_DUTY: cfg.max_duty             = i_pwdata[DUTY_W-1:0];
                    REG_DEF_SP:   cfg.default_setpoint     = i_pwdata[SP_W-1:0];
                    REG_IDLE_TO:  cfg.idle_timeout_seconds = i_pwdata[CNT_W-1:0];
                    REG_OFF_TO:   cfg.off_timeout_minutes  = i_pwdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_tick(t_item'(i_s_tdata[$bits(t_item)-1:0]), next_result);
                expected_results.push_back(next_result);
            end
            o_pending <= expected_results.size();
            o_heating <= (setpoint != '0);
        end
        o_fail_count <= fails;
    end

endmodule

>>> verif/heater_tool_supervisor_unit_tb.sv
// Testbench top for the heater tool supervisor: clock, reset, tick and register stimulus, verdict.
`timescale 1ns / 1ps
module heater_tool_supervisor_unit_tb;
    import hts_pkg::*;

    localparam realtime CLK_HALF     = 6.0;
    localparam realtime RUN_LIMIT_NS = 10_000_000.0;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tready = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr         = '0;
    logic [APB_DATA_W-1:0]  pwdata        = '0;

    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int                     exp_pending;
    int                     fail_count;
    logic                   heating;

    logic                   rx_idle_en   = 1'b0;
    int                     rx_hold      = 0;
    bit                     tx_idle_en   = 1'b0;
    bit                     idle_allowed = 1'b1;
    int                     ticks_sent   = 0;
    int unsigned            def_sp_now   = RST_DEF_SP;

    heater_tool_supervisor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hts_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (exp_pending),
        .o_heating    (heating),
        .o_fail_count (fail_count)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // result side: random stall bursts
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_hold       <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_item item_of(input int unsigned temp, input logic ev,
                                      input logic lvl, input logic mot);
        t_item it;
        it.tip_temperature = TEMP_W'(temp);
        it.button_event    = ev;
        it.button_level    = lvl;
        it.motion_event    = mot;
        return it;
    endfunction

    function automatic int unsigned pick_temp();
        int unsigned lo;
        lo = (def_sp_now > 40) ? def_sp_now - 40 : 0;
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1023);
            1:       return $urandom_range(45, 65);
            2:       return $urandom_range(lo, def_sp_now + 20);
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    function automatic t_item make_tick(input logic ev, input logic lvl, input logic mot);
        return item_of(pick_temp(), ev, lvl, mot);
    endfunction

    task automatic send_tick(input t_item it);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(it);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exp_pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // back-to-back writes go straight from access to the next setup phase
    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned gain, input int unsigned max_duty,
                              input int unsigned def_sp, input int unsigned idle_to,
                              input int unsigned off_to);
        drain();
        write_reg(REG_GAIN, gain);
        write_reg(REG_MAX_DUTY, max_duty);
        write_reg(REG_DEF_SP, def_sp);
        write_reg(REG_IDLE_TO, idle_to);
        write_reg(REG_OFF_TO, off_to);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        def_sp_now = def_sp;
    endtask

    task automatic long_press(input int motion_pct);
        send_tick(make_tick(1'b1, 1'b1, chance(motion_pct)));
        repeat ($urandom_range(6, 8))
            send_tick(make_tick(chance(10), 1'b1, chance(motion_pct)));
        repeat ($urandom_range(1, 3))
            send_tick(make_tick(1'b0, 1'b0, chance(motion_pct)));
    endtask

    task automatic short_press(input int held);
        send_tick(make_tick(1'b1, 1'b1, 1'b0));
        repeat (held) send_tick(make_tick(1'b0, 1'b1, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 1'b0));
    endtask

    task automatic run_quiet(input int n, input int motion_pct);
        repeat (n) send_tick(make_tick(1'b0, chance(5), chance(motion_pct)));
    endtask

    task automatic run_random(input int n, input int motion_pct);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < n) begin
            if (idle_allowed && chance(20))
                tx_idle_en = !tx_idle_en;
            if (idle_allowed && chance(20))
                rx_idle_en <= !rx_idle_en;
            case ($urandom_range(0, 9))
                0, 1, 2: long_press(motion_pct);
                3, 4:    short_press($urandom_range(0, 5));
                5, 6, 7: run_quiet($urandom_range(3, 40), motion_pct);
                default: begin
                    repeat ($urandom_range(1, 10))
                        send_tick(item_of($urandom_range(0, 1023), 1'($urandom),
                                          1'($urandom), 1'($urandom)));
                end
            endcase
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int spin;
        repeat (10) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        rx_idle_en <= 1'b1;
        tx_idle_en  = 1'b1;
        @(posedge i_clk);

        // directed ticks at reset register values
        send_tick(item_of(0, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(1023, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(55, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(56, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(100, 1'b0, 1'b0, 1'b1));   // motion flash while off
        send_tick(item_of(20, 1'b1, 1'b0, 1'b0));    // press released at once
        long_press(0);                               // enable from default
        send_tick(item_of(30, 1'b1, 1'b1, 1'b0));    // inside ignore window
        send_tick(item_of(30, 1'b1, 1'b1, 1'b0));
        send_tick(item_of(320, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(321, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(0, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(305, 1'b0, 1'b0, 1'b0));
        send_tick(item_of(304, 1'b0, 1'b0, 1'b1));
        short_press(1);                              // disable, saves setpoint

        set_config(255, 100, 510, 3, 0);
        run_random(250, 5);

        set_config(0, 0, 0, 0, 255);
        run_random(200, 5);

        set_config(1, 127, $urandom_range(1, 510), 1, 0);
        run_random(250, 10);

        // idle and off timeouts expiring in the same second
        set_config($urandom_range(1, 255), $urandom_range(1, 100),
                   $urandom_range(100, 510), 60, 1);
        run_quiet(4, 0);
        drain();
        if (heating) begin
            short_press(1);
            run_quiet(4, 0);
        end
        long_press(0);
        run_quiet(620, 0);
        run_random(100, 3);

        set_config($urandom_range(0, 255), $urandom_range(0, 100),
                   $urandom_range(1, 510), $urandom_range(0, 8), $urandom_range(0, 3));
        run_random(150, 4);
        drain();                                     // let every result come out
        run_random(150, 4);

        // closing stretch with no idling on either side
        set_config($urandom_range(0, 255), $urandom_range(0, 100),
                   $urandom_range(1, 510), $urandom_range(1, 5), 0);
        idle_allowed = 1'b0;
        tx_idle_en   = 1'b0;
        rx_idle_en  <= 1'b0;
        run_random(200, 6);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (spin = 0; spin < 1000 && exp_pending != 0; spin++)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && exp_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
